@@ rtl/core/frpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frpm_pkg
// Shared types and constants for the framed route prefix matcher.
// ----------------------------------------------------------------------------
package frpm_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int ADDR_W        = 32;
  localparam int SLOT_W        = 4;
  localparam int CNT_W         = SLOT_W + 1;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_ADDRESS  = 2'd0,
    CFG_RULE_NETMASK  = 2'd1,
    CFG_ACTIVE_ROUTES = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_WRITE  = 1'b1
  } mode_e;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] netmask;
    logic              present;
  } wr_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  function automatic logic prefix_hit(logic [ADDR_W-1:0] addr,
                                      logic [ADDR_W-1:0] net,
                                      logic [ADDR_W-1:0] mask);
    prefix_hit = ((addr ^ net) & mask) == '0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/frpm_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frpm_cell
// One route table entry that compares the passing lookup item and hands it on.
// ----------------------------------------------------------------------------
module frpm_cell
  import frpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] idx_i,
  input  wr_t               wr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [ADDR_W-1:0] network_q;
  logic [ADDR_W-1:0] netmask_q;
  logic              valid_q;
  logic              hit;
  tok_t              tok_d;
  tok_t              tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.slot == idx_i)) begin
      network_q <= wr_i.network;
      netmask_q <= wr_i.netmask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.en && (wr_i.slot == idx_i)) begin
      valid_q <= wr_i.present;
    end
  end

  assign hit = tok_i.vld && !tok_i.found && valid_q && ({1'b0, idx_i} < tok_i.cnt)
               && prefix_hit(tok_i.addr, network_q, netmask_q);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.slot  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

@@ rtl/core/framed_route_prefix_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// framed_route_prefix_match
// Classifies an IPv4 address against a rule and a table of framed routes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result is shown
// for exactly one cycle with done_o high; the receiver cannot hold it off. A
// table write and a lookup that hits the rule give their result in the cycle after
// the item is taken, and busy stays low. A lookup that misses the rule walks
// the row of sixteen route cells, one cell per cycle; its result is registered
// after the last cell, and busy is high while the item walks the row. A write
// is seen by any later lookup.
module framed_route_prefix_match
  import frpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [ADDR_W-1:0]    lookup_address_i,
  input  logic [SLOT_W-1:0]    entry_slot_i,
  input  logic [ADDR_W-1:0]    entry_network_i,
  input  logic [ADDR_W-1:0]    entry_netmask_i,
  input  logic                 entry_present_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  output logic                 done_o,
  output logic                 matched_o,
  output logic                 via_route_o,
  output logic [SLOT_W-1:0]    hit_slot_o
);

  logic [ADDR_W-1:0]        rule_address_q;
  logic [ADDR_W-1:0]        rule_netmask_q;
  logic [CNT_W-1:0]         active_routes_q;
  logic                     busy_q, busy_d;
  logic                     accept, is_write, rule_hit;
  logic                     done_q, done_d;
  logic                     matched_q, matched_d;
  logic                     via_q, via_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  wr_t                      wr;
  tok_t                     tok [ROUTE_ENTRIES+1];
  logic [ROUTE_ENTRIES-1:0] tok_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_address_q  <= '0;
      rule_netmask_q  <= '0;
      active_routes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RULE_ADDRESS:  rule_address_q  <= cfg_data_i;
        CFG_RULE_NETMASK:  rule_netmask_q  <= cfg_data_i;
        CFG_ACTIVE_ROUTES: active_routes_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = start && !busy_q;
  assign is_write = (mode_i == MODE_WRITE);
  assign rule_hit = prefix_hit(lookup_address_i, rule_address_q, rule_netmask_q);

  assign wr.en      = accept && is_write;
  assign wr.slot    = entry_slot_i;
  assign wr.network = entry_network_i;
  assign wr.netmask = entry_netmask_i;
  assign wr.present = entry_present_i;

  assign tok[0].vld   = accept && !is_write && !rule_hit;
  assign tok[0].addr  = lookup_address_i;
  assign tok[0].cnt   = active_routes_q;
  assign tok[0].found = 1'b0;
  assign tok[0].slot  = '0;

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    frpm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(g)),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  always_comb begin
    busy_d = busy_q;
    if (tok[0].vld) begin
      busy_d = 1'b1;
    end else if (tok[ROUTE_ENTRIES].vld) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    done_d    = 1'b0;
    matched_d = 1'b0;
    via_d     = 1'b0;
    slot_d    = '0;
    if (tok[ROUTE_ENTRIES].vld) begin
      done_d    = 1'b1;
      matched_d = tok[ROUTE_ENTRIES].found;
      via_d     = tok[ROUTE_ENTRIES].found;
      slot_d    = tok[ROUTE_ENTRIES].slot;
    end else if (accept && (is_write || rule_hit)) begin
      done_d    = 1'b1;
      matched_d = !is_write;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    via_q     <= via_d;
    slot_q    <= slot_d;
  end

  assign busy        = busy_q;
  assign done_o      = done_q;
  assign matched_o   = matched_q;
  assign via_route_o = via_q;
  assign hit_slot_o  = slot_q;

  a_via_implies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && via_route_o |-> matched_o)
    else $error("route hit reported without a match");

  a_slot_zero_without_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !via_route_o |-> hit_slot_o == '0)
    else $error("nonzero slot on a result that is not a route hit");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i == MODE_WRITE) |=> done_o && !matched_o)
    else $error("write item did not give an empty result");

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one lookup item in the cell row");

  a_busy_while_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld != '0) && !tok[ROUTE_ENTRIES].vld |-> busy)
    else $error("busy low while a lookup item walks the cell row");

endmodule
`default_nettype wire
